>>> sv/json_string_control_char_escaper_defines.svh
// ----------------------------------------------------------------------------
// JSON control-char escaper assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_CONTROL_CHAR_ESCAPER_DEFINES_SVH
`define JSON_STRING_CONTROL_CHAR_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define JSCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsce assertion failed");
// antecedent implies consequent in the next cycle
`define JSCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsce assertion failed");
`else
`define JSCE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define JSCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/jsce_pkg.sv
// ----------------------------------------------------------------------------
// jsce_pkg
// Shared types, character codes and helpers for the JSON escaper.
// ----------------------------------------------------------------------------
package jsce_pkg;

  // character codes
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  // step of a six-byte escape sequence
  typedef logic [2:0] step_t;
  localparam step_t STEP_BSLASH = 3'd0;
  localparam step_t STEP_U      = 3'd1;
  localparam step_t STEP_ZERO_A = 3'd2;
  localparam step_t STEP_ZERO_B = 3'd3;
  localparam step_t STEP_HEX_HI = 3'd4;
  localparam step_t STEP_HEX_LO = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } out_beat_t;

  // classified command from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       expand;
    logic       final_byte;
  } cmd_t;

  // front parser state
  typedef struct packed {
    logic str_open;
    logic pending;
  } front_state_t;

  // lowercase hex digit
  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

endpackage

>>> sv/jsce_front.sv
// ----------------------------------------------------------------------------
// jsce_front
// Tracks string and backslash state and classifies each input byte.
// ----------------------------------------------------------------------------
module jsce_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  jsce_pkg::in_beat_t    in_data,
  output jsce_pkg::cmd_t        cmd,
  output jsce_pkg::front_state_t state
);

  logic inside_r, inside_nxt;
  logic pending_r, pending_nxt;
  logic expand;

  // classification and next state
  always_comb begin
    inside_nxt  = inside_r;
    pending_nxt = pending_r;
    expand      = 1'b0;
    if (inside_r) begin
      if (pending_r) begin
        pending_nxt = 1'b0;
      end else if (in_data.in_byte == jsce_pkg::CH_BSLASH) begin
        pending_nxt = 1'b1;
      end else if (in_data.in_byte == jsce_pkg::CH_QUOTE) begin
        inside_nxt = 1'b0;
      end else if (in_data.in_byte < jsce_pkg::CTRL_LIMIT) begin
        expand = 1'b1;
      end
    end else begin
      if (in_data.in_byte == jsce_pkg::CH_QUOTE) begin
        inside_nxt = 1'b1;
      end
      pending_nxt = 1'b0;
    end
    // message end clears all state
    if (in_data.in_final) begin
      inside_nxt  = 1'b0;
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= 1'b0;
      pending_r <= 1'b0;
    end else if (accept) begin
      inside_r  <= inside_nxt;
      pending_r <= pending_nxt;
    end
  end

  assign cmd.data       = in_data.in_byte;
  assign cmd.expand     = expand;
  assign cmd.final_byte = in_data.in_final;

  assign state.str_open = inside_r;
  assign state.pending  = pending_r;

endmodule

>>> sv/jsce_fifo.sv
// ----------------------------------------------------------------------------
// jsce_fifo
// Short show-ahead command queue between front and back.
// ----------------------------------------------------------------------------
module jsce_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  jsce_pkg::cmd_t             wr_cmd,
  input  logic                       pop,
  output jsce_pkg::cmd_t             head,
  output logic                       head_valid,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  jsce_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // pointers with wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_FULL);
  assign count      = count_r;

endmodule

>>> sv/jsce_back.sv
// ----------------------------------------------------------------------------
// jsce_back
// Expands queued commands into output beats, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jsce_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jsce_pkg::cmd_t       head,
  input  logic                 head_valid,
  output logic                 pop,
  output jsce_pkg::step_t      step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output jsce_pkg::out_beat_t  out_data
);

  logic                out_valid_r, out_valid_nxt;
  jsce_pkg::out_beat_t out_data_r, out_data_nxt;
  jsce_pkg::step_t     step_r, step_nxt;
  logic                load;
  logic                last_beat;
  logic [7:0]          esc_byte;

  // byte of the escape sequence at the current step
  always_comb begin
    case (step_r)
      jsce_pkg::STEP_BSLASH: esc_byte = jsce_pkg::CH_BSLASH;
      jsce_pkg::STEP_U:      esc_byte = jsce_pkg::CH_U;
      jsce_pkg::STEP_ZERO_A: esc_byte = jsce_pkg::CH_ZERO;
      jsce_pkg::STEP_ZERO_B: esc_byte = jsce_pkg::CH_ZERO;
      jsce_pkg::STEP_HEX_HI: esc_byte = jsce_pkg::hex_lower(head.data[7:4]);
      jsce_pkg::STEP_HEX_LO: esc_byte = jsce_pkg::hex_lower(head.data[3:0]);
      default:               esc_byte = jsce_pkg::CH_BSLASH;
    endcase
  end

  // output register loads when empty or draining
  always_comb begin
    load      = head_valid && (!out_valid_r || !out_stall);
    last_beat = !head.expand || (step_r == jsce_pkg::STEP_HEX_LO);
    pop       = load && last_beat;

    out_data_nxt.out_byte    = head.expand ? esc_byte : head.data;
    out_data_nxt.run_last    = last_beat;
    out_data_nxt.message_end = last_beat && head.final_byte;

    out_valid_nxt = load || (out_valid_r && out_stall);

    step_nxt = step_r;
    if (load) begin
      step_nxt = last_beat ? jsce_pkg::STEP_BSLASH : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= jsce_pkg::STEP_BSLASH;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign step      = step_r;

endmodule

>>> sv/json_string_control_char_escaper.sv
// An accepted input beat is written to the command queue, then to the back-end output register.
// Throughput: one input byte per cycle unless the queue is full or the output stalls; a control
// byte inside a string becomes six emitted bytes, each a load of the back-end output register.
// The command queue (QUEUE_DEPTH entries) absorbs short stalls on either side.
// Reset: synchronous active-low; clears string/escape state, empties the queue
// and drops the output beat. No clearing pass.
// ----------------------------------------------------------------------------
// json_string_control_char_escaper
// Escapes control bytes inside JSON string literals as \u00xx.
// ----------------------------------------------------------------------------
`include "json_string_control_char_escaper_defines.svh"

module json_string_control_char_escaper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jsce_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jsce_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH+1);
  localparam logic [CW-1:0] CNT_MAX = CW'(QUEUE_DEPTH);

  logic                   in_accept;
  jsce_pkg::cmd_t         cmd;
  jsce_pkg::front_state_t fstate;
  jsce_pkg::cmd_t         head;
  logic                   head_valid;
  logic                   full;
  logic [CW-1:0]          count;
  logic                   pop;
  jsce_pkg::step_t        step;
  logic                   state_idle;

  // input handshake
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = full;

  jsce_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_data (in_data),
    .cmd     (cmd),
    .state   (fstate)
  );

  jsce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .wr_cmd     (cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full),
    .count      (count)
  );

  jsce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .step       (step),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // parser back at its idle state
  assign state_idle = !fstate.str_open && !fstate.pending;

  // checks
  `JSCE_ASSERT_NEXT(a_final_clears, clk, rst_n, in_accept && in_data.in_final, state_idle)
  `JSCE_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count <= CNT_MAX)
  `JSCE_ASSERT_SAME(a_step_expand, clk, rst_n, step != jsce_pkg::STEP_BSLASH, head_valid && head.expand)
  `JSCE_ASSERT_SAME(a_end_is_last, clk, rst_n, out_valid && out_data.message_end, out_data.run_last)

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON control-char escaper: a directed run over
// string entry and exit, backslash escapes, control bytes and message ends,
// then random JSON-like traffic under varied sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // character codes used by the predictor and the stimulus
  localparam logic [7:0] QUOTE_CHAR   = 8'h22;
  localparam logic [7:0] BSLASH_CHAR  = 8'h5c;
  localparam logic [7:0] U_CHAR       = 8'h75;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] CTRL_BOUND   = 8'h20;
  localparam logic [7:0] LETTER_CAP_A = 8'h41;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  jsce_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  jsce_pkg::out_beat_t out_data;

  // escaper state as seen by the predictor
  logic      str_open;
  logic      esc_pending;

  jsce_pkg::out_beat_t escaped_q[$];
  int        mismatches;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  json_string_control_char_escaper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // lowercase hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return DIGIT_ZERO + {4'h0, nib};
    end
    return LOWER_A + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void push_escaped(input logic [7:0] b, input logic last,
                                       input logic fin);
    jsce_pkg::out_beat_t e;
    e.out_byte    = b;
    e.run_last    = last;
    e.message_end = last & fin;
    escaped_q.push_back(e);
  endfunction

  // expected output beats for one input byte, updates string/escape state
  function automatic void predict_escape(input logic [7:0] b, input logic fin);
    if (str_open) begin
      if (esc_pending) begin
        esc_pending = 1'b0;
        push_escaped(b, 1'b1, fin);
      end else if (b == BSLASH_CHAR) begin
        esc_pending = 1'b1;
        push_escaped(b, 1'b1, fin);
      end else if (b == QUOTE_CHAR) begin
        str_open = 1'b0;
        push_escaped(b, 1'b1, fin);
      end else if (b < CTRL_BOUND) begin
        push_escaped(BSLASH_CHAR, 1'b0, fin);
        push_escaped(U_CHAR, 1'b0, fin);
        push_escaped(DIGIT_ZERO, 1'b0, fin);
        push_escaped(DIGIT_ZERO, 1'b0, fin);
        push_escaped(hex_digit(b[7:4]), 1'b0, fin);
        push_escaped(hex_digit(b[3:0]), 1'b1, fin);
      end else begin
        push_escaped(b, 1'b1, fin);
      end
    end else begin
      if (b == QUOTE_CHAR) begin
        str_open = 1'b1;
      end
      esc_pending = 1'b0;
      push_escaped(b, 1'b1, fin);
    end
    if (fin) begin
      str_open    = 1'b0;
      esc_pending = 1'b0;
    end
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // send one input beat; called after a falling edge, returns once accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    predict_escape(b, fin);
    in_valid         = 1'b1;
    in_data.in_byte  = b;
    in_data.in_final = fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold the sender off until every expected beat has come out
  task automatic wait_drained;
    in_valid = 1'b0;
    while (escaped_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // bytes outside strings pass unchanged, control bytes too
  task automatic test_outside_strings;
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h1f, 1'b0);
    send_byte(LETTER_CAP_A, 1'b1);
  endtask

  // control bytes inside a string expand, others pass
  task automatic test_control_escapes;
    send_byte(QUOTE_CHAR, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h1f, 1'b0);
    send_byte(8'h0a, 1'b0);
    send_byte(CTRL_BOUND, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(QUOTE_CHAR, 1'b1);
  endtask

  // a byte after a backslash passes unchanged, quote included
  task automatic test_escaped_bytes;
    send_byte(QUOTE_CHAR, 1'b0);
    send_byte(BSLASH_CHAR, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(BSLASH_CHAR, 1'b0);
    send_byte(QUOTE_CHAR, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(BSLASH_CHAR, 1'b0);
    send_byte(BSLASH_CHAR, 1'b0);
    send_byte(QUOTE_CHAR, 1'b0);
  endtask

  // final byte clears state, backslash at the end leaves nothing pending
  task automatic test_final_resets;
    send_byte(QUOTE_CHAR, 1'b0);
    send_byte(BSLASH_CHAR, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(QUOTE_CHAR, 1'b0);
    send_byte(8'h03, 1'b1);
  endtask

  // JSON-like random messages: strings, escapes, control and raw bytes
  task automatic test_random_traffic(input int n_items);
    int         pick;
    logic [7:0] b;
    logic       fin;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        b = QUOTE_CHAR;
      end else if (pick < 24) begin
        b = BSLASH_CHAR;
      end else if (pick < 50) begin
        b = 8'($urandom_range(31));
      end else begin
        b = 8'($urandom_range(255));
      end
      fin = ($urandom_range(11) == 0);
      send_byte(b, fin);
    end
  endtask

  // receiver stall, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each output beat with the oldest expectation
  always @(posedge clk) begin
    jsce_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (escaped_q.size() == 0) begin
        flag_error($sformatf("unexpected beat byte=%02h last=%0b end=%0b",
                             out_data.out_byte, out_data.run_last,
                             out_data.message_end));
      end else begin
        want = escaped_q.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.run_last !== want.run_last ||
            out_data.message_end !== want.message_end) begin
          flag_error($sformatf(
            "want byte=%02h last=%0b end=%0b, got byte=%02h last=%0b end=%0b",
            want.out_byte, want.run_last, want.message_end,
            out_data.out_byte, out_data.run_last, out_data.message_end));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    str_open      = 1'b0;
    esc_pending   = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    send_idle_pct = 18;
    recv_idle_pct = 76;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_outside_strings;
    test_control_escapes;
    test_escaped_bytes;
    test_final_resets;
    wait_drained;

    test_random_traffic(45);
    send_idle_pct = 76;
    recv_idle_pct = 18;
    test_random_traffic(45);
    wait_drained;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(45);

    in_valid = 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && escaped_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
